>>> sv/demand_paging_translator_unit_assert.svh
// Assertion macros for the demand paging translator.
`ifndef DEMAND_PAGING_TRANSLATOR_UNIT_ASSERT_SVH
`define DEMAND_PAGING_TRANSLATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define DPT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("dpt assertion failed");
`define DPT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
	else $error("dpt forbidden condition");
`else
`define DPT_ASSERT(lbl, prop)
`define DPT_NEVER(lbl, expr)
`endif
`endif

>>> sv/dpt_pkg.sv
// Shared types, codes and helpers of the demand paging translator.
package dpt_pkg;

	typedef enum logic [2:0] {
		OP_READ  = 3'd0,
		OP_WRITE = 3'd1,
		OP_EXEC  = 3'd2,
		OP_ATTR  = 3'd3,
		OP_LOAD  = 3'd4,
		OP_AGE   = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		STS_OK      = 3'd0,
		STS_RD_DENY = 3'd1,
		STS_WR_DENY = 3'd2,
		STS_EX_DENY = 3'd3,
		STS_FOREIGN = 3'd4,
		STS_INVALID = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PT,
		S_FSCAN,
		S_VSCAN1,
		S_VSCAN2,
		S_VWAIT,
		S_COPYOUT,
		S_COPYIN,
		S_UPD,
		S_MEMRD,
		S_DONE
	} fsm_t;

	typedef struct packed {
		logic done;
		logic found;
	} scan_stat_t;

	// Result item, last field in the lowest bits.
	typedef struct packed {
		logic [15:0] use_count;
		logic [5:0]  victim_page;
		logic        written_back;
		logic        replaced;
		logic        page_fault;
		logic [6:0]  phys_addr;
		logic [7:0]  read_data;
		logic [2:0]  status;
	} result_t;

	localparam logic [15:0] HIT_MAX = 16'hFFFF;

	function automatic logic [15:0] hits_sat(input logic [15:0] h);
		return (h == HIT_MAX) ? h : h + 16'd1;
	endfunction

	function automatic logic [2:0] deny_status(input logic [2:0] op);
		logic [2:0] s;
		case (op)
			OP_READ:  s = STS_RD_DENY;
			OP_WRITE: s = STS_WR_DENY;
			default:  s = STS_EX_DENY;
		endcase
		return s;
	endfunction

endpackage

>>> sv/demand_paging_translator_unit.sv
// Top level of the demand paging translator with not-recently-used replacement.
//
// Requests arrive as transfers on the s_axis channel: op, byte address, process,
// write data and protection. Every request yields exactly one result transfer on
// m_axis: status, read byte, physical address, fault and eviction flags, victim
// page and the page's use count.
// The page table lives in a synchronous RAM with a registered read; the
// whole table, physical memory and backing store are handled one request at a
// time by a sequencer. A hit passes the table read and the table update before
// the result register loads; a read adds the physical memory read. A fault adds
// the free-frame scan and the copy-in. With no free frame, the victim scan (up
// to two passes over the pages), one victim table read, and a copy-out when
// the victim is dirty come before the copy-in. Side ops (backing load, aging
// tick, invalid op) go from idle straight to the result, a protection update
// after the table read. Once the result is loaded the block returns to idle.
// After reset all pages are absent, owned by process 0 and inaccessible, every
// frame is free; no clearing pass is needed. The result register lets the next
// request be taken while a result waits; when the receiver stalls, the block
// finishes that next request and then holds it until the register frees up.
// PAGE_BYTES and PAGES are powers of two.
module demand_paging_translator_unit #(
	parameter int PAGE_BYTES = 4,
	parameter int PAGES      = 64,
	parameter int FRAMES     = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// op[2:0], virt_addr[10:3], proc_id[14:11], write_data[22:15], prot[25:23]
	input  logic [31:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status[2:0], read_data[10:3], phys_addr[17:11], page_fault[18],
	// replaced[19], written_back[20], victim_page[26:21], use_count[42:27]
	output logic [47:0] m_axis_tdata
);
	localparam int OFFW = $clog2(PAGE_BYTES);
	localparam int PW   = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int FW   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int PAW  = FW + OFFW;
	localparam int BAW  = PW + OFFW;

	typedef struct packed {
		logic [FW-1:0] frame;
		logic [15:0]   hits;
		logic [2:0]    prot;
		logic [3:0]    owner;
	} pte_t;

	// Input fields.
	logic [2:0]      in_op;
	logic [7:0]      in_va;
	logic [3:0]      in_pid;
	logic [7:0]      in_wd;
	logic [2:0]      in_prot;
	logic [PW+7:0]   va_sh;
	logic [PW-1:0]   in_page;
	logic [OFFW-1:0] in_off;

	assign in_op   = s_axis_tdata[2:0];
	assign in_va   = s_axis_tdata[10:3];
	assign in_pid  = s_axis_tdata[14:11];
	assign in_wd   = s_axis_tdata[22:15];
	assign in_prot = s_axis_tdata[25:23];
	assign va_sh   = {{PW{1'b0}}, in_va} >> OFFW;
	assign in_page = va_sh[PW-1:0];
	assign in_off  = in_va[OFFW-1:0];

	dpt_pkg::fsm_t st_q, st_d;

	// Request registers.
	logic [2:0]      op_q;
	logic [PW-1:0]   page_q;
	logic [OFFW-1:0] off_q;
	logic [3:0]      pid_q;
	logic [7:0]      wd_q;
	logic [2:0]      prot_q;
	pte_t            ent_q;
	logic            fault_q;
	logic [PW-1:0]   v_q;
	logic [FW-1:0]   vframe_q;
	logic [FW-1:0]   frame_q;
	logic [OFFW:0]   ci_q;
	dpt_pkg::result_t res_q;

	// Copy pipeline: each byte is read, then written in the following cycle.
	logic            cp_vld_s1;
	logic            cp_dir_s1;
	logic [OFFW-1:0] cp_idx_s1;

	// Per-page and per-frame flags.
	logic [PAGES-1:0]  present_q, dirty_q, ref_q, ptv_q;
	logic [FRAMES-1:0] frame_used_q;

	// Memories.
	pte_t       ptab [PAGES];
	logic [7:0] phys_mem [FRAMES*PAGE_BYTES];
	logic [7:0] backing [PAGES*PAGE_BYTES];
	pte_t       pt_rd_q;
	logic       pt_rvld_q;
	logic [7:0] phys_rd_q, bk_rd_q;

	logic [PW-1:0]  pt_raddr, pt_waddr;
	logic           pt_we;
	pte_t           pt_wdata;
	logic [PAW-1:0] phys_raddr, phys_waddr;
	logic           phys_we;
	logic [7:0]     phys_wdata;
	logic [BAW-1:0] bk_raddr, bk_waddr;
	logic           bk_we;
	logic [7:0]     bk_wdata;

	// Scanners.
	logic                 fs_start, ps_start;
	dpt_pkg::scan_stat_t  fs_stat, ps_stat;
	logic [FW-1:0]        fs_idx;
	logic [PW-1:0]        ps_idx;
	logic [PAGES-1:0]     ps_vec;

	dpt_scan #(.N(FRAMES)) u_fscan (
		.clk(clk), .arst_n(arst_n), .start(fs_start), .vec(~frame_used_q),
		.stat(fs_stat), .idx(fs_idx)
	);

	dpt_scan #(.N(PAGES)) u_pscan (
		.clk(clk), .arst_n(arst_n), .start(ps_start), .vec(ps_vec),
		.stat(ps_stat), .idx(ps_idx)
	);

	pte_t ent_now;
	logic accept, allowed, out_load;

	assign ent_now = pt_rvld_q ? pt_rd_q : '0;
	assign accept  = s_axis_tvalid & s_axis_tready;
	assign allowed = ent_q.prot[op_q[1:0]];
	assign out_load = (st_q == dpt_pkg::S_DONE) & (~m_axis_tvalid | m_axis_tready);

	always_comb begin
		st_d          = st_q;
		s_axis_tready = (st_q == dpt_pkg::S_IDLE);
		fs_start      = 1'b0;
		ps_start      = 1'b0;
		ps_vec        = present_q & ~ref_q;
		pt_raddr      = page_q;
		pt_we         = 1'b0;
		pt_waddr      = page_q;
		pt_wdata      = {frame_q, dpt_pkg::hits_sat(ent_q.hits), ent_q.prot, ent_q.owner};
		phys_raddr    = {vframe_q, ci_q[OFFW-1:0]};
		phys_we       = cp_vld_s1 & cp_dir_s1;
		phys_waddr    = {frame_q, cp_idx_s1};
		phys_wdata    = bk_rd_q;
		bk_raddr      = {page_q, ci_q[OFFW-1:0]};
		bk_we         = cp_vld_s1 & ~cp_dir_s1;
		bk_waddr      = {v_q, cp_idx_s1};
		bk_wdata      = phys_rd_q;
		case (st_q)
			dpt_pkg::S_IDLE: begin
				pt_raddr = in_page;
				if (s_axis_tvalid) begin
					case (in_op)
						dpt_pkg::OP_READ, dpt_pkg::OP_WRITE,
						dpt_pkg::OP_EXEC, dpt_pkg::OP_ATTR: st_d = dpt_pkg::S_PT;
						dpt_pkg::OP_LOAD: begin
							bk_we    = 1'b1;
							bk_waddr = {in_page, in_off};
							bk_wdata = in_wd;
							st_d     = dpt_pkg::S_DONE;
						end
						default: st_d = dpt_pkg::S_DONE;
					endcase
				end
			end
			dpt_pkg::S_PT: begin
				if (op_q == dpt_pkg::OP_ATTR) begin
					pt_we    = 1'b1;
					pt_wdata = {ent_now.frame, ent_now.hits, prot_q, pid_q};
					st_d     = dpt_pkg::S_DONE;
				end else if (pid_q != ent_now.owner) begin
					pt_we    = 1'b1;
					pt_wdata = {ent_now.frame, dpt_pkg::hits_sat(ent_now.hits),
						ent_now.prot, ent_now.owner};
					st_d     = dpt_pkg::S_DONE;
				end else if (present_q[page_q]) begin
					st_d = dpt_pkg::S_UPD;
				end else begin
					fs_start = 1'b1;
					st_d     = dpt_pkg::S_FSCAN;
				end
			end
			dpt_pkg::S_FSCAN: begin
				if (fs_stat.done) begin
					if (fs_stat.found) begin
						st_d = dpt_pkg::S_COPYIN;
					end else begin
						ps_start = 1'b1;
						st_d     = dpt_pkg::S_VSCAN1;
					end
				end
			end
			dpt_pkg::S_VSCAN1: begin
				if (ps_stat.done) begin
					if (ps_stat.found) begin
						pt_raddr = ps_idx;
						st_d     = dpt_pkg::S_VWAIT;
					end else begin
						ps_start = 1'b1;
						st_d     = dpt_pkg::S_VSCAN2;
					end
				end
			end
			dpt_pkg::S_VSCAN2: begin
				ps_vec = present_q;
				if (ps_stat.done) begin
					pt_raddr = ps_idx;
					st_d     = dpt_pkg::S_VWAIT;
				end
			end
			dpt_pkg::S_VWAIT: begin
				st_d = dirty_q[v_q] ? dpt_pkg::S_COPYOUT : dpt_pkg::S_COPYIN;
			end
			dpt_pkg::S_COPYOUT: begin
				if (ci_q[OFFW]) st_d = dpt_pkg::S_COPYIN;
			end
			dpt_pkg::S_COPYIN: begin
				if (ci_q[OFFW]) st_d = dpt_pkg::S_UPD;
			end
			dpt_pkg::S_UPD: begin
				pt_we      = 1'b1;
				phys_raddr = {frame_q, off_q};
				if (allowed && op_q == dpt_pkg::OP_WRITE) begin
					phys_we    = 1'b1;
					phys_waddr = {frame_q, off_q};
					phys_wdata = wd_q;
				end
				st_d = (allowed && op_q == dpt_pkg::OP_READ) ? dpt_pkg::S_MEMRD
					: dpt_pkg::S_DONE;
			end
			dpt_pkg::S_MEMRD: st_d = dpt_pkg::S_DONE;
			dpt_pkg::S_DONE: begin
				if (out_load) st_d = dpt_pkg::S_IDLE;
			end
			default: st_d = dpt_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= dpt_pkg::S_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// Memories: one write and one registered read per cycle each.
	always_ff @(posedge clk) begin
		if (pt_we) ptab[pt_waddr] <= pt_wdata;
		pt_rd_q <= ptab[pt_raddr];
		if (phys_we) phys_mem[phys_waddr] <= phys_wdata;
		phys_rd_q <= phys_mem[phys_raddr];
		if (bk_we) backing[bk_waddr] <= bk_wdata;
		bk_rd_q <= backing[bk_raddr];
	end

	// Control flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q    <= '0;
			dirty_q      <= '0;
			ref_q        <= '0;
			ptv_q        <= '0;
			frame_used_q <= '0;
			pt_rvld_q    <= 1'b0;
			cp_vld_s1    <= 1'b0;
			fault_q      <= 1'b0;
			ci_q         <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			pt_rvld_q <= ptv_q[pt_raddr];
			if (pt_we) ptv_q[pt_waddr] <= 1'b1;
			cp_vld_s1 <= (st_q == dpt_pkg::S_COPYOUT || st_q == dpt_pkg::S_COPYIN)
				&& !ci_q[OFFW];
			if (st_q == dpt_pkg::S_COPYOUT || st_q == dpt_pkg::S_COPYIN) begin
				ci_q <= ci_q[OFFW] ? '0 : ci_q + (OFFW+1)'(1);
			end
			if (accept) begin
				fault_q <= 1'b0;
				if (in_op == dpt_pkg::OP_AGE) ref_q <= '0;
			end
			case (st_q)
				dpt_pkg::S_PT: begin
					if (op_q != dpt_pkg::OP_ATTR) begin
						if (pid_q != ent_now.owner) ref_q[page_q] <= 1'b1;
						else if (!present_q[page_q]) fault_q <= 1'b1;
					end
				end
				dpt_pkg::S_FSCAN: begin
					if (fs_stat.done && fs_stat.found) frame_used_q[fs_idx] <= 1'b1;
				end
				dpt_pkg::S_VWAIT: begin
					present_q[v_q] <= 1'b0;
					dirty_q[v_q]   <= 1'b0;
					ref_q[v_q]     <= 1'b0;
				end
				dpt_pkg::S_UPD: begin
					present_q[page_q] <= 1'b1;
					ref_q[page_q]     <= 1'b1;
					if (allowed && op_q == dpt_pkg::OP_WRITE) dirty_q[page_q] <= 1'b1;
					else if (fault_q) dirty_q[page_q] <= 1'b0;
				end
				default: ;
			endcase
			if (out_load) m_axis_tvalid <= 1'b1;
			else if (m_axis_tready) m_axis_tvalid <= 1'b0;
		end
	end

	// Request and result payload.
	always_ff @(posedge clk) begin
		cp_dir_s1 <= (st_q == dpt_pkg::S_COPYIN);
		cp_idx_s1 <= ci_q[OFFW-1:0];
		if (accept) begin
			op_q   <= in_op;
			page_q <= in_page;
			off_q  <= in_off;
			pid_q  <= in_pid;
			wd_q   <= in_wd;
			prot_q <= in_prot;
			res_q  <= {40'd0, (in_op > dpt_pkg::OP_AGE) ? dpt_pkg::STS_INVALID
				: dpt_pkg::STS_OK};
		end
		case (st_q)
			dpt_pkg::S_PT: begin
				ent_q   <= ent_now;
				frame_q <= ent_now.frame;
				if (op_q != dpt_pkg::OP_ATTR) begin
					if (pid_q != ent_now.owner) begin
						res_q.status    <= dpt_pkg::STS_FOREIGN;
						res_q.use_count <= dpt_pkg::hits_sat(ent_now.hits);
					end else if (!present_q[page_q]) begin
						res_q.page_fault <= 1'b1;
					end
				end
			end
			dpt_pkg::S_FSCAN: begin
				if (fs_stat.done && fs_stat.found) begin
					frame_q    <= fs_idx;
					ent_q.hits <= '0;
				end
			end
			dpt_pkg::S_VSCAN1, dpt_pkg::S_VSCAN2: begin
				if (ps_stat.done) v_q <= ps_idx;
			end
			dpt_pkg::S_VWAIT: begin
				vframe_q           <= pt_rvld_q ? pt_rd_q.frame : '0;
				frame_q            <= pt_rvld_q ? pt_rd_q.frame : '0;
				res_q.replaced     <= 1'b1;
				res_q.victim_page  <= 6'(v_q);
				res_q.written_back <= dirty_q[v_q];
			end
			dpt_pkg::S_UPD: begin
				res_q.phys_addr <= 7'({frame_q, off_q});
				res_q.use_count <= dpt_pkg::hits_sat(ent_q.hits);
				if (!allowed) res_q.status <= dpt_pkg::deny_status(op_q);
			end
			dpt_pkg::S_MEMRD: res_q.read_data <= phys_rd_q;
			default: ;
		endcase
		if (out_load) m_axis_tdata <= {5'b0, res_q};
	end

`include "demand_paging_translator_unit_assert.svh"
	`DPT_ASSERT(a_accept_leaves_idle, accept |=> st_q != dpt_pkg::S_IDLE)
	`DPT_NEVER(a_copy_pending_in_upd, st_q == dpt_pkg::S_UPD && cp_vld_s1)
	`DPT_ASSERT(a_evict_only_when_full, st_q == dpt_pkg::S_VWAIT |-> &frame_used_q)
	`DPT_ASSERT(a_replace_implies_fault,
		(st_q == dpt_pkg::S_DONE && res_q.replaced) |-> res_q.page_fault)
endmodule

>>> sv/dpt_scan.sv
// Sequential first-set-bit scanner, one element per cycle.
module dpt_scan #(
	parameter int N = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [N-1:0]                   vec,
	output dpt_pkg::scan_stat_t            stat,
	output logic [(N > 1 ? $clog2(N) : 1)-1:0] idx
);
	localparam int IW = (N > 1) ? $clog2(N) : 1;

	logic          busy_q;
	logic [IW-1:0] idx_q;

	assign stat.found = busy_q & vec[idx_q];
	assign stat.done  = busy_q & (vec[idx_q] | (idx_q == IW'(N - 1)));
	assign idx        = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (stat.done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			idx_q <= idx_q + IW'(1);
		end
	end
endmodule
